[sv/ctl_pkg.sv]
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared types and constants of the color transfer lookup block: table entry
// layout, the request and response of the shared blend unit, register
// indexes and item codes.
// ----------------------------------------------------------------------------
package ctl_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int FRAC_BITS = 16;

    localparam int POS_W   = 32;
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int SEG_W   = 4;

    // Narrowest segment width that is not treated as zero width
    // (width * 100000 < 2^FRAC_BITS means the segment is skipped).
    localparam logic [POS_W-1:0] MIN_WIDTH =
        POS_W'(((64'd1 << FRAC_BITS) + 64'd99999) / 64'd100000);

    // Item codes carried in s_tuser.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = CNT_W;
    localparam logic [CFG_ADDR_W-1:0] REG_BANDED_MODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NODE_COUNT  = 1'd1;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [COLOR_W-1:0]      color;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [CH_W-1:0]  c0;
        logic [CH_W-1:0]  c1;
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] s;
    } blend_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [CH_W-1:0] quotient;
    } blend_rsp_t;

endpackage

[sv/color_transfer_lookup_top.sv]
// ----------------------------------------------------------------------------
// color_transfer_lookup_top
// Maps a signed Q15.16 sample to an RGB color through a table of nodes, by
// band lookup or by piecewise linear interpolation between nodes.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries items. s_tuser selects the kind: a write item
//   stores a node position and color at entry_index and gives no result; a
//   lookup item scans the first node_count entries (at most 16) and gives one result on
//   the m_ channel. cfg_wr_en writes banded_mode (index 0) or node_count
//   (index 1); write them only while the block is idle.
//   A write item leaves the block idle. A lookup scans one table entry per
//   cycle out of the single read port of the node table. A banded hit or a
//   miss then goes straight on to the output register; a piecewise hit runs
//   the shared blend unit once per color channel, each run in two multiply
//   steps and eight divide steps.
//   One item is worked on at a time; s_tready is high only while idle.
//   The result waits in an output register; the next item is taken while it
//   waits, and a finished lookup holds until the register is free.
//   Reset clears the registers to banded mode with an empty table count and
//   drops m_tvalid; table entries are undefined until written.
// ----------------------------------------------------------------------------
module color_transfer_lookup_top
    import ctl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index[3:0], value_q16[35:4], in_red[43:36], in_green[51:44],
    // in_blue[59:52], zero[63:60]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // opcode[0]
    input  logic                  s_tuser,
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], segment[27:24],
    // zero[31:28]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // matched[0]
    output logic                  m_tuser
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE       = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN       = 3'd1;
    localparam logic [ST_W-1:0] ST_BLEND      = 3'd2;
    localparam logic [ST_W-1:0] ST_BLEND_WAIT = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE       = 3'd4;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [ST_W-1:0]        state_reg, state_next;
    logic                   banded_mode_reg;
    logic [CNT_W-1:0]       node_count_reg;
    logic signed [POS_W-1:0] sample_reg;
    logic [CNT_W-1:0]       k_reg;
    logic                   have_reg;
    entry_t                 prev_reg;
    logic [COLOR_W-1:0]     c0_reg;
    logic [COLOR_W-1:0]     c1_reg;
    logic [POS_W-1:0]       r_reg;
    logic [POS_W-1:0]       s_reg;
    logic [1:0]             ch_reg;
    logic [COLOR_W-1:0]     res_color_reg;
    logic                   res_matched_reg;
    logic [SEG_W-1:0]       res_seg_reg;
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   in_fire;
    logic [IDX_W-1:0]       in_index;
    entry_t                 in_entry;
    logic [CNT_W-1:0]       n_lim;
    logic                   rd_en;
    entry_t                 cur;
    logic [CNT_W-1:0]       e_idx;
    logic                   in_range;
    logic [POS_W:0]         width_wide;
    logic [POS_W:0]         offs_wide;
    logic                   band_hit;
    logic                   seg_hit;
    logic                   scan_end;
    logic                   out_load;
    blend_req_t             breq;
    blend_rsp_t             brsp;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_entry.pos   = s_tdata[35:4];
    assign in_entry.color = {s_tdata[43:36], s_tdata[51:44], s_tdata[59:52]};

    assign n_lim = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                        : node_count_reg;
    assign rd_en = (state_reg == ST_SCAN) && (k_reg < n_lim);

    ctl_table u_table (
        .aclk    (aclk),
        .wr_en   (in_fire && (s_tuser == OP_WRITE)),
        .wr_addr (in_index),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (k_reg[IDX_W-1:0]),
        .rd_data (cur)
    );

    // Entry e_idx is in cur, entry e_idx - 1 in prev_reg.
    assign e_idx      = k_reg - CNT_W'(1);
    assign in_range   = ($signed(prev_reg.pos) <= sample_reg) &&
                        (sample_reg <= $signed(cur.pos));
    assign width_wide = {cur.pos[POS_W-1], cur.pos} -
                        {prev_reg.pos[POS_W-1], prev_reg.pos};
    assign offs_wide  = {sample_reg[POS_W-1], sample_reg} -
                        {prev_reg.pos[POS_W-1], prev_reg.pos};
    assign band_hit   = have_reg && banded_mode_reg && e_idx[0] && in_range;
    assign seg_hit    = have_reg && !banded_mode_reg && (e_idx != '0) && in_range &&
                        (width_wide[POS_W-1:0] >= MIN_WIDTH);
    assign scan_end   = (k_reg >= n_lim);

    always_comb begin
        breq.start = (state_reg == ST_BLEND);
        breq.r     = r_reg;
        breq.s     = s_reg;
        case (ch_reg)
            CH_RED: begin
                breq.c0 = c0_reg[23:16];
                breq.c1 = c1_reg[23:16];
            end
            CH_GREEN: begin
                breq.c0 = c0_reg[15:8];
                breq.c1 = c1_reg[15:8];
            end
            default: begin
                breq.c0 = c0_reg[7:0];
                breq.c1 = c1_reg[7:0];
            end
        endcase
    end

    ctl_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (breq),
        .rsp     (brsp)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_tuser == OP_LOOKUP)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (seg_hit) begin
                    state_next = ST_BLEND;
                end else if (band_hit || scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_BLEND: begin
                if (!brsp.busy) begin
                    state_next = ST_BLEND_WAIT;
                end
            end
            ST_BLEND_WAIT: begin
                if (brsp.done) begin
                    state_next = (ch_reg == CH_BLUE) ? ST_DONE : ST_BLEND;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            banded_mode_reg <= 1'b1;
            node_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_BANDED_MODE: banded_mode_reg <= cfg_wdata[0];
                    REG_NODE_COUNT:  node_count_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sample_reg      <= s_tdata[35:4];
            k_reg           <= '0;
            have_reg        <= 1'b0;
            ch_reg          <= CH_RED;
            res_color_reg   <= '0;
            res_matched_reg <= 1'b0;
            res_seg_reg     <= '0;
        end
        if (state_reg == ST_SCAN) begin
            if (rd_en) begin
                k_reg <= k_reg + CNT_W'(1);
            end
            have_reg <= rd_en;
            if (have_reg) begin
                prev_reg <= cur;
            end
            if (band_hit) begin
                res_color_reg   <= prev_reg.color;
                res_matched_reg <= 1'b1;
                res_seg_reg     <= SEG_W'(e_idx >> 1);
            end
            if (seg_hit) begin
                c0_reg          <= prev_reg.color;
                c1_reg          <= cur.color;
                r_reg           <= width_wide[POS_W-1:0];
                s_reg           <= offs_wide[POS_W-1:0];
                res_matched_reg <= 1'b1;
                res_seg_reg     <= SEG_W'(e_idx - CNT_W'(1));
            end
        end
        if ((state_reg == ST_BLEND_WAIT) && brsp.done) begin
            ch_reg <= ch_reg + 2'd1;
            case (ch_reg)
                CH_RED:   res_color_reg[23:16] <= brsp.quotient;
                CH_GREEN: res_color_reg[15:8]  <= brsp.quotient;
                default:  res_color_reg[7:0]   <= brsp.quotient;
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= {4'd0, res_seg_reg, res_color_reg[7:0],
                            res_color_reg[15:8], res_color_reg[23:16]};
            m_tuser_reg <= res_matched_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[sv/ctl_table.sv]
// ----------------------------------------------------------------------------
// ctl_table
// Node table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctl_table
    import ctl_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_NODES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ctl_blend.sv]
// ----------------------------------------------------------------------------
// ctl_blend
// Shared blend unit: forms c0*(r-s) + c1*s in two multiply steps, then divides
// by r with a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctl_blend
    import ctl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  blend_req_t req,
    output blend_rsp_t rsp
);

    localparam int ACC_W  = POS_W + CH_W;
    localparam int DIV_W  = POS_W + CH_W - 1;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_MUL0     = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_MUL1     = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_DIV_LAST = STEP_W'(CH_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CH_W-1:0]   c0_reg;
    logic [CH_W-1:0]   c1_reg;
    logic [POS_W-1:0]  r_reg;
    logic [POS_W-1:0]  s_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [CH_W-1:0]   quo_reg;

    logic [ACC_W-1:0]  prod_a;
    logic [ACC_W-1:0]  prod_b;
    logic [ACC_W:0]    trial;

    assign prod_a = ACC_W'(c0_reg) * ACC_W'(r_reg - s_reg);
    assign prod_b = ACC_W'(c1_reg) * ACC_W'(s_reg);
    assign trial  = {1'b0, acc_reg} - (ACC_W + 1)'(div_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_MUL0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_MUL0;
                end
            end else begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_DIV_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg) begin
            if (req.start) begin
                c0_reg <= req.c0;
                c1_reg <= req.c1;
                r_reg  <= req.r;
                s_reg  <= req.s;
            end
        end else if (step_reg == STEP_MUL0) begin
            acc_reg <= prod_a;
        end else if (step_reg == STEP_MUL1) begin
            acc_reg <= acc_reg + prod_b;
            div_reg <= {r_reg, (CH_W - 1)'(0)};
        end else begin
            // The sum is below 256*r, so eight steps give the whole quotient.
            if (!trial[ACC_W]) begin
                acc_reg <= trial[ACC_W-1:0];
            end
            quo_reg <= {quo_reg[CH_W-2:0], ~trial[ACC_W]};
            div_reg <= div_reg >> 1;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
